@@ hdl/rwcp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser package
// Chunk identifiers, result kind codes and the front-to-back descriptor.
// ----------------------------------------------------------------------------
package rwcp_pkg;

    // Four-character codes as little-endian 32-bit words
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_TOTAL  = 2'd2;

    // Work for the back end caused by one accepted byte
    typedef struct packed {
        logic        sample;   // emit a sample byte
        logic        reject;   // emit a header rejection
        logic        total;    // emit the end-of-file total (after any sample)
        logic [7:0]  byte_val;
        logic [31:0] sum;
    } desc_t;

endpackage
`default_nettype wire

@@ hdl/rwcp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser front end
// Tracks header/chunk phase per byte and pushes result descriptors.
// ----------------------------------------------------------------------------
module rwcp_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            queue_full,
    input  wire logic [7:0]      file_byte,
    input  wire logic            last_of_file,
    input  wire logic            pad_odd_chunks,
    output logic                 push,
    output rwcp_pkg::desc_t      push_desc
);

    typedef enum logic [2:0] {
        PH_MASTER  = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_PAD     = 3'd3,
        PH_REJECT  = 3'd4
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [3:0]  cnt_reg,     cnt_next;
    logic [31:0] id_reg,      id_next;
    logic [31:0] size_reg,    size_next;
    logic [31:0] remain_reg,  remain_next;
    logic        is_data_reg, is_data_next;
    logic        pad_reg,     pad_next;
    logic [31:0] total_reg,   total_next;

    logic        accept;
    logic        bad;
    logic [32:0] sum_wide;
    rwcp_pkg::desc_t d;

    assign accept = in_valid && !queue_full;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        id_next      = id_reg;
        size_next    = size_reg;
        remain_next  = remain_reg;
        is_data_next = is_data_reg;
        pad_next     = pad_reg;
        total_next   = total_reg;
        bad          = 1'b0;
        sum_wide     = {1'b0, total_reg} + {1'b0, size_reg};
        d            = '0;

        unique case (phase_reg)
            PH_MASTER:
            begin
                if (cnt_reg < 4'd4 || cnt_reg >= 4'd8)
                    id_next = {file_byte, id_reg[31:8]};
                else
                    size_next = {file_byte, size_reg[31:8]};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3 && id_next != rwcp_pkg::ID_RIFF)
                    bad = 1'b1;
                if (cnt_reg == 4'd11)
                begin
                    if (id_next != rwcp_pkg::ID_WAVE)
                        bad = 1'b1;
                    else
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = 4'd0;
                    end
                end
                if (bad)
                begin
                    d.reject   = 1'b1;
                    phase_next = PH_REJECT;
                end
                else if (last_of_file && phase_next == PH_MASTER)
                    d.reject = 1'b1;   // file ended inside the master header
            end
            PH_HEADER:
            begin
                if (cnt_reg < 4'd4)
                    id_next = {file_byte, id_reg[31:8]};
                else
                    size_next = {file_byte, size_reg[31:8]};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7)
                begin
                    remain_next  = size_next;
                    is_data_next = (id_next == rwcp_pkg::ID_DATA);
                    pad_next     = pad_odd_chunks & size_next[0];
                    sum_wide     = {1'b0, total_reg} + {1'b0, size_next};
                    if (is_data_next)
                        total_next = sum_wide[32] ? 32'hffff_ffff : sum_wide[31:0];
                    cnt_next = 4'd0;
                    if (size_next == 32'd0)
                        phase_next = pad_next ? PH_PAD : PH_HEADER;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                d.sample    = is_data_reg;
                d.byte_val  = file_byte;
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    phase_next = pad_reg ? PH_PAD : PH_HEADER;
                    cnt_next   = 4'd0;
                end
            end
            PH_PAD:
            begin
                pad_next   = 1'b0;
                phase_next = PH_HEADER;
                cnt_next   = 4'd0;
            end
            default:
            begin
                // rejected file (and unused codes): swallow bytes
            end
        endcase

        if (last_of_file)
        begin
            if (phase_next == PH_HEADER || phase_next == PH_PAYLOAD || phase_next == PH_PAD)
            begin
                d.total = 1'b1;
                d.sum   = total_next;
            end
            phase_next   = PH_MASTER;
            cnt_next     = 4'd0;
            id_next      = '0;
            size_next    = '0;
            remain_next  = '0;
            is_data_next = 1'b0;
            pad_next     = 1'b0;
            total_next   = '0;
        end
    end

    assign push      = accept && (d.sample || d.reject || d.total);
    assign push_desc = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MASTER;
            cnt_reg     <= '0;
            id_reg      <= '0;
            size_reg    <= '0;
            remain_reg  <= '0;
            is_data_reg <= 1'b0;
            pad_reg     <= 1'b0;
            total_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            id_reg      <= id_next;
            size_reg    <= size_next;
            remain_reg  <= remain_next;
            is_data_reg <= is_data_next;
            pad_reg     <= pad_next;
            total_reg   <= total_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/rwcp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser descriptor queue
// Small register FIFO between front and back ends.
// ----------------------------------------------------------------------------
module rwcp_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rwcp_pkg::desc_t push_desc,
    input  wire logic            pop,
    output logic                 full,
    output logic                 empty,
    output rwcp_pkg::desc_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rwcp_pkg::desc_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule
`default_nettype wire

@@ hdl/rwcp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser back end
// Expands descriptors into result transfers through an output register.
// ----------------------------------------------------------------------------
module rwcp_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            queue_empty,
    input  wire rwcp_pkg::desc_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [1:0]           kind,
    output logic [7:0]           sample_byte,
    output logic [31:0]          data_total,
    output logic                 end_of_run
);

    logic        valid_reg,  valid_next;
    logic        second_reg, second_next;   // sample sent, total still owed
    logic [1:0]  kind_reg,   kind_next;
    logic [7:0]  byte_reg,   byte_next;
    logic [31:0] total_reg,  total_next;
    logic        eor_reg,    eor_next;
    logic        load;

    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        total_next  = total_reg;
        eor_next    = eor_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = !queue_empty;
            if (!queue_empty)
            begin
                byte_next  = 8'd0;
                total_next = 32'd0;
                eor_next   = 1'b1;
                if (second_reg)
                begin
                    kind_next   = rwcp_pkg::KIND_TOTAL;
                    total_next  = head.sum;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end
                else if (head.sample)
                begin
                    kind_next = rwcp_pkg::KIND_SAMPLE;
                    byte_next = head.byte_val;
                    if (head.total)
                    begin
                        eor_next    = 1'b0;
                        second_next = 1'b1;
                    end
                    else
                        pop = 1'b1;
                end
                else if (head.reject)
                begin
                    kind_next = rwcp_pkg::KIND_REJECT;
                    pop       = 1'b1;
                end
                else
                begin
                    kind_next  = rwcp_pkg::KIND_TOTAL;
                    total_next = head.sum;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        total_reg <= total_next;
        eor_reg   <= eor_next;
    end

    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign sample_byte = byte_reg;
    assign data_total  = total_reg;
    assign end_of_run  = eor_reg;

endmodule
`default_nettype wire

@@ hdl/riff_wave_chunk_parser_unit.sv @@
// Path: a byte's result is written into the descriptor queue, then into the output register.
// Throughput: one file byte per cycle while the descriptor queue is not full (in_stall);
//   the last byte of a file inside a data payload yields two results, a sample and then
//   the total, both from one queued descriptor.
// Reset: rst_n asynchronously clears parser state, the queue and the output valid;
//   pad_odd_chunks resets to 0. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RIFF/WAVE chunk parser
// Checks the RIFF/WAVE master header, walks chunk headers, forwards the
// payload of data chunks and reports the total data size at end of file.
// ----------------------------------------------------------------------------
module riff_wave_chunk_parser_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: pad_odd_chunks
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_write_data,
    // byte input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  file_byte,
    input  wire logic        last_of_file,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       sample_byte,
    output logic [31:0]      data_total,
    output logic             end_of_run
);

    logic            pad_odd_chunks_reg;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    rwcp_pkg::desc_t q_push_desc;
    rwcp_pkg::desc_t q_head;

    // Config register; sampled by the front end when a chunk header completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_odd_chunks_reg <= 1'b0;
        else if (cfg_write_en)
            pad_odd_chunks_reg <= cfg_write_data;
    end

    // Byte transfers stall only when the descriptor queue is full, so the
    // input keeps moving while a result waits at the output.
    assign in_stall = q_full;

    // Front end: phase tracking, header checks, chunk size bookkeeping
    rwcp_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .queue_full     (q_full),
        .file_byte      (file_byte),
        .last_of_file   (last_of_file),
        .pad_odd_chunks (pad_odd_chunks_reg),
        .push           (q_push),
        .push_desc      (q_push_desc)
    );

    // Descriptor queue decouples parsing from output back-pressure
    rwcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back end: one result transfer per cycle from queued descriptors while out_stall is low
    rwcp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .head        (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .sample_byte (sample_byte),
        .data_total  (data_total),
        .end_of_run  (end_of_run)
    );

endmodule
`default_nettype wire
